### src/sne_pkg.sv
`default_nettype none

package sne_pkg;

	localparam int unsigned SNE_VALUE_WIDTH = 32;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	// Status of the byte held in the input stage, seen by the top level
	typedef struct packed {
		logic emit;       // byte ends a numeric run: a result leaves on this step
		logic saturated;  // magnitude of the finished run was clamped
	} sne_flags_t;

	function automatic logic is_digit(input logic [7:0] c);
		logic [7:0] off;
		off = c - CHAR_ZERO;
		return off < 8'd10;
	endfunction

	function automatic logic is_numeric(input logic [7:0] c);
		return is_digit(c) || (c == CHAR_MINUS) || (c == CHAR_PLUS);
	endfunction

endpackage

`default_nettype wire

### src/sne_mac.sv
`default_nettype none

// Saturating multiply-by-ten accumulate of one decimal digit
module sne_mac #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic [VALUE_WIDTH-1:0] mag,
	input  logic                   negative,
	input  logic                   overflow,
	input  logic [3:0]             digit,
	output logic [VALUE_WIDTH-1:0] mag_next,
	output logic                   overflow_next
);
	import sne_pkg::*;

	localparam int unsigned PW = VALUE_WIDTH + 4;

	logic [VALUE_WIDTH-1:0] limit;
	logic [PW-1:0]          wide;
	logic [PW-1:0]          prod;

	always_comb begin
		// negative runs may reach one further than positive ones
		limit = negative ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
			: {1'b0, {(VALUE_WIDTH-1){1'b1}}};
		wide  = {4'b0000, mag};
		prod  = (wide << 3) + (wide << 1) + {{(PW-4){1'b0}}, digit};
		if (overflow) begin
			mag_next      = mag;
			overflow_next = 1'b1;
		end else if (prod > {4'b0000, limit}) begin
			mag_next      = limit;
			overflow_next = 1'b1;
		end else begin
			mag_next      = prod[VALUE_WIDTH-1:0];
			overflow_next = 1'b0;
		end
	end

endmodule

`default_nettype wire

### src/sne_scan.sv
`default_nettype none

// Scanner state: skip / comment tracking and atoi run evaluation
module sne_scan #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [7:0]             char_s1,
	input  logic                   step,
	output sne_pkg::sne_flags_t    flags,
	output logic [VALUE_WIDTH-1:0] value
);
	import sne_pkg::*;

	typedef enum logic [1:0] {
		MODE_SKIP,
		MODE_SLASH,
		MODE_BODY,
		MODE_RUN
	} mode_t;

	typedef enum logic [1:0] {
		PH_START,
		PH_DIGIT,
		PH_TAIL
	} phase_t;

	mode_t                  mode_q,  mode_d;
	phase_t                 phase_q, phase_d;
	logic                   neg_q,   neg_d;
	logic [VALUE_WIDTH-1:0] mag_q,   mag_d;
	logic                   ovf_q,   ovf_d;

	logic                   numeric, digit, slash, in_run, run_step;
	phase_t                 eff_phase;
	logic                   eff_neg, eff_ovf;
	logic [VALUE_WIDTH-1:0] eff_mag;
	logic [VALUE_WIDTH-1:0] mac_mag;
	logic                   mac_ovf;

	sne_mac #(.VALUE_WIDTH(VALUE_WIDTH)) u_mac (
		.mag          (eff_mag),
		.negative     (eff_neg),
		.overflow     (eff_ovf),
		.digit        (char_s1[3:0]),
		.mag_next     (mac_mag),
		.overflow_next(mac_ovf)
	);

	always_comb begin
		numeric  = is_numeric(char_s1);
		digit    = is_digit(char_s1);
		slash    = (char_s1 == CHAR_SLASH);
		in_run   = (mode_q == MODE_RUN);
		run_step = numeric && (in_run || (mode_q == MODE_SKIP));

		// a run opened by this byte starts from cleared fields
		eff_phase = in_run ? phase_q : PH_START;
		eff_neg   = in_run && neg_q;
		eff_ovf   = in_run && ovf_q;
		eff_mag   = in_run ? mag_q : '0;

		mode_d  = mode_q;
		phase_d = eff_phase;
		neg_d   = eff_neg;
		mag_d   = eff_mag;
		ovf_d   = eff_ovf;

		if (run_step) begin
			mode_d = MODE_RUN;
			unique case (eff_phase)
				PH_START: begin
					if (digit) begin
						mag_d = mac_mag;
						ovf_d = mac_ovf;
					end else begin
						neg_d = (char_s1 == CHAR_MINUS);
					end
					phase_d = PH_DIGIT;
				end
				PH_DIGIT: begin
					if (digit) begin
						mag_d = mac_mag;
						ovf_d = mac_ovf;
					end else begin
						phase_d = PH_TAIL;
					end
				end
				default: begin
					phase_d = PH_TAIL;
				end
			endcase
		end else begin
			unique case (mode_q)
				MODE_RUN: begin
					// run ends; the same byte then goes through skip logic
					phase_d = PH_START;
					neg_d   = 1'b0;
					mag_d   = '0;
					ovf_d   = 1'b0;
					mode_d  = slash ? MODE_SLASH : MODE_SKIP;
				end
				MODE_SLASH: mode_d = slash ? MODE_SKIP : MODE_BODY;
				MODE_BODY:  mode_d = slash ? MODE_SKIP : MODE_BODY;
				default:    mode_d = slash ? MODE_SLASH : MODE_SKIP;
			endcase
		end

		flags.emit      = in_run && !numeric;
		flags.saturated = ovf_q;
		value           = neg_q ? ('0 - mag_q) : mag_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_SKIP;
			phase_q <= PH_START;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (step) begin
			mode_q  <= mode_d;
			phase_q <= phase_d;
			neg_q   <= neg_d;
			mag_q   <= mag_d;
			ovf_q   <= ovf_d;
		end
	end

	// clamped magnitude sits exactly at the limit for the run's sign
	a_ovf_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (mag_q == (neg_q ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
			: {1'b0, {(VALUE_WIDTH-1){1'b1}}})))
		else $error("overflow flag set but magnitude not at limit");

	// outside a run the run fields stay cleared
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_RUN) |-> (!ovf_q && !neg_q && (mag_q == '0)))
		else $error("run fields not cleared outside a run");

	// a run cannot leave the start phase without seeing a byte
	a_run_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_RUN) |-> (phase_q != PH_START))
		else $error("run active in start phase");

endmodule

`default_nettype wire

### src/script_number_extractor.sv
`default_nettype none

// Channel   Signals                        Direction  Payload
// -------   -----------------------------  ---------  ----------------------------
// input     in_valid / in_ready            sink       char_in (8 bit byte)
// result    out_valid / out_ready          source     value (signed), saturated
//
// One byte per cycle sustained while the input stage does not stall: a byte
// transfers into the input stage, is evaluated combinationally by the scanner,
// and any result is registered in the output register as the byte that ends
// its run leaves the input stage.
// The input stage stalls only when its byte ends a run while the output
// register still holds a result not yet taken.
// Reset (arst_n low) empties both stages and returns the scanner to skip mode.
module script_number_extractor #(
	parameter int unsigned VALUE_WIDTH = sne_pkg::SNE_VALUE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [7:0]                    char_in,
	input  logic                          in_valid,
	output logic                          in_ready,
	output logic signed [VALUE_WIDTH-1:0] value,
	output logic                          saturated,
	output logic                          out_valid,
	input  logic                          out_ready
);
	import sne_pkg::*;

	// input stage
	logic [7:0] char_s1;
	logic       valid_s1;

	// result register
	logic [VALUE_WIDTH-1:0] value_q;
	logic                   saturated_q;
	logic                   out_valid_q;

	sne_flags_t             flags;
	logic [VALUE_WIDTH-1:0] scan_value;
	logic                   slot_free;
	logic                   fire_s1;
	logic                   load_out;

	// result slot is free when empty or being drained this cycle
	assign slot_free = !out_valid_q || out_ready;
	// advance the held byte unless it needs the result slot and that is busy
	assign fire_s1   = valid_s1 && (!flags.emit || slot_free);
	assign load_out  = fire_s1 && flags.emit;
	assign in_ready  = !valid_s1 || fire_s1;

	sne_scan #(.VALUE_WIDTH(VALUE_WIDTH)) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.char_s1(char_s1),
		.step   (fire_s1),
		.flags  (flags),
		.value  (scan_value)
	);

	// input stage: hold the byte until the scanner takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_in;
		end
	end

	// output register: load a finished run, drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			value_q     <= scan_value;
			saturated_q <= flags.saturated;
		end
	end

	assign value     = signed'(value_q);
	assign saturated = saturated_q;
	assign out_valid = out_valid_q;

	// a run that ends always shows a result on the next cycle
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q)
		else $error("finished run did not reach the output register");

	// a clamped result carries one of the two extreme values
	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && saturated_q) |->
			((value_q == {1'b1, {(VALUE_WIDTH-1){1'b0}}})
			|| (value_q == {1'b0, {(VALUE_WIDTH-1){1'b1}}})))
		else $error("saturated result not at range limit");

	// a byte blocked behind a waiting result holds in the input stage
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && flags.emit && out_valid_q && !out_ready) |=>
			(valid_s1 && $stable(char_s1)))
		else $error("stalled byte lost from input stage");

endmodule

`default_nettype wire
